// ----- rtl/awct_pkg.sv -----
// shared types and codes for the address wakeup counter table
package awct_pkg;

   typedef enum logic [1:0] {
      OP_RECORD = 2'd0,
      OP_REPORT = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   localparam logic [63:0] V4_ADDR_MASK  = 64'h0000_0000_FFFF_FFFF;
   localparam logic [31:0] V4_OWNER_MASK = 32'h0003_FFFF;
   localparam int          V4_COUNT_W    = 14;

   typedef struct packed {
      logic        v6;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [31:0] owner;
      logic [31:0] count;
   } entry_type;

endpackage

// ----- rtl/address_wakeup_counter_table_top.sv -----
// address wakeup counter table: per-address counters with least-frequent replacement
//
// One request is taken at a time; req_stall is high while it is worked on. The
// table lives in a single memory with one write port and one registered read
// port, walked by a small sequencer with a read state and a check or compare
// state for every entry it reads. A record that hits or fills a free slot
// stops its scan at that slot. A record that misses a full table first scans
// all TABLE_ENTRIES slots; it and every report then bubble-sort the used
// entries by count, descending and stable, with up to n passes of n-1
// compares for n used entries. A report then walks all TABLE_ENTRIES slots
// to sum counts and emit the top REPORT_TOP entries (at most TABLE_ENTRIES;
// slots past the fill count go out marked invalid) and the total. A clear
// only zeroes the fill count. The number of used slots is kept as a fill
// count, so no clearing pass follows reset.
module address_wakeup_counter_table_top
   import awct_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   parameter int REPORT_TOP    = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic        req_is_v6,
   input  logic [63:0] req_addr_hi,
   input  logic [63:0] req_addr_lo,
   input  logic [31:0] req_owner_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_total,
   output logic        rsp_entry_valid,
   output logic        rsp_entry_v6,
   output logic [63:0] rsp_entry_addr_high,
   output logic [63:0] rsp_entry_addr_low,
   output logic [31:0] rsp_entry_owner,
   output logic [31:0] rsp_entry_count,
   output logic [31:0] rsp_total_count,
   output logic        rsp_last
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int REPORT_COUNT = (REPORT_TOP < TABLE_ENTRIES) ? REPORT_TOP : TABLE_ENTRIES;
   localparam logic [CNT_W-1:0] FULL_N  = CNT_W'(TABLE_ENTRIES);
   localparam logic [CNT_W-1:0] LAST_N  = CNT_W'(TABLE_ENTRIES - 1);
   localparam logic [CNT_W-1:0] REP_N   = CNT_W'(REPORT_COUNT);
   localparam logic [CNT_W-1:0] ONE_N   = CNT_W'(1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SORT_START,
      S_SORT_LD0,
      S_SORT_LD1,
      S_SORT_RD,
      S_SORT_CMP,
      S_SORT_END,
      S_SORT_DONE,
      S_REC_EMIT,
      S_REP_RD,
      S_REP_CHK,
      S_REP_EMIT,
      S_TOTAL
   } state_type;

   state_type        state_ff;
   op_type           op_ff;
   entry_type        req_ff;
   entry_type        res_ff;
   entry_type        carry_ff;
   entry_type        rd_data_ff;
   logic             swapped_ff;
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] idx_ff;
   logic [31:0]      total_ff;

   logic             rsp_valid_ff;
   logic             rsp_is_total_ff;
   logic             rsp_entry_valid_ff;
   entry_type        rsp_entry_ff;
   logic [31:0]      rsp_total_ff;
   logic             rsp_last_ff;

   entry_type        table_mem [TABLE_ENTRIES];

   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   entry_type        mem_wd;
   logic [IDX_W-1:0] mem_ra;
   logic             out_free;
   logic             emit_state;
   logic             hit;
   entry_type        new_entry;
   entry_type        upd_entry;
   logic [CNT_W-1:0] idx_next;
   logic [CNT_W-1:0] idx_prev;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit_state = (state_ff == S_REC_EMIT) || (state_ff == S_REP_EMIT)
                       || (state_ff == S_TOTAL);
   assign mem_ra   = idx_ff[IDX_W-1:0];
   assign idx_next = idx_ff + ONE_N;
   assign idx_prev = idx_ff - ONE_N;

   always_comb begin
      new_entry       = req_ff;
      new_entry.count = 32'd1;
      upd_entry       = rd_data_ff;
      if (rd_data_ff.owner == 32'd0) begin
         upd_entry.owner = req_ff.owner;
      end
      if (req_ff.v6) begin
         upd_entry.count = rd_data_ff.count + 32'd1;
      end else begin
         upd_entry.count = {18'd0, rd_data_ff.count[V4_COUNT_W-1:0] + 14'd1};
      end
      hit = (rd_data_ff.v6 == req_ff.v6) && (rd_data_ff.hi == req_ff.hi)
            && (rd_data_ff.lo == req_ff.lo);
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = idx_ff[IDX_W-1:0];
      mem_wd = new_entry;
      case (state_ff)
         S_SCAN_RD: begin
            if (idx_ff == fill_ff && fill_ff != FULL_N) begin
               mem_we = 1'b1;
            end
         end
         S_SCAN_CHK: begin
            if (hit) begin
               mem_we = 1'b1;
               mem_wd = upd_entry;
            end
         end
         S_SORT_CMP: begin
            mem_we = 1'b1;
            mem_wa = idx_prev[IDX_W-1:0];
            mem_wd = (rd_data_ff.count > carry_ff.count) ? rd_data_ff : carry_ff;
         end
         S_SORT_END: begin
            mem_we = 1'b1;
            mem_wa = idx_prev[IDX_W-1:0];
            mem_wd = carry_ff;
         end
         S_SORT_DONE: begin
            if (op_ff == OP_RECORD) begin
               mem_we = 1'b1;
               mem_wa = LAST_N[IDX_W-1:0];
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= table_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !emit_state) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff        <= op_type'(req_operation);
                  req_ff.v6    <= req_is_v6;
                  req_ff.hi    <= req_is_v6 ? req_addr_hi : 64'd0;
                  req_ff.lo    <= req_is_v6 ? req_addr_lo : (req_addr_lo & V4_ADDR_MASK);
                  req_ff.owner <= req_is_v6 ? req_owner_id : (req_owner_id & V4_OWNER_MASK);
                  req_ff.count <= 32'd0;
                  idx_ff       <= '0;
                  case (op_type'(req_operation))
                     OP_RECORD: state_ff <= S_SCAN_RD;
                     OP_REPORT: state_ff <= S_SORT_START;
                     OP_CLEAR:  fill_ff  <= '0;
                     default:   state_ff <= S_IDLE;
                  endcase
               end
            end
            S_SCAN_RD: begin
               if (idx_ff == fill_ff) begin
                  if (fill_ff != FULL_N) begin
                     fill_ff  <= fill_ff + ONE_N;
                     res_ff   <= new_entry;
                     state_ff <= S_REC_EMIT;
                  end else begin
                     state_ff <= S_SORT_START;
                  end
               end else begin
                  state_ff <= S_SCAN_CHK;
               end
            end
            S_SCAN_CHK: begin
               if (hit) begin
                  res_ff   <= upd_entry;
                  state_ff <= S_REC_EMIT;
               end else begin
                  idx_ff   <= idx_next;
                  state_ff <= S_SCAN_RD;
               end
            end
            S_SORT_START: begin
               idx_ff   <= '0;
               state_ff <= (fill_ff > ONE_N) ? S_SORT_LD0 : S_SORT_DONE;
            end
            S_SORT_LD0: begin
               state_ff <= S_SORT_LD1;
            end
            S_SORT_LD1: begin
               carry_ff   <= rd_data_ff;
               swapped_ff <= 1'b0;
               idx_ff     <= ONE_N;
               state_ff   <= S_SORT_RD;
            end
            S_SORT_RD: begin
               state_ff <= S_SORT_CMP;
            end
            S_SORT_CMP: begin
               if (rd_data_ff.count > carry_ff.count) begin
                  swapped_ff <= 1'b1;
               end else begin
                  carry_ff <= rd_data_ff;
               end
               idx_ff   <= idx_next;
               state_ff <= (idx_next == fill_ff) ? S_SORT_END : S_SORT_RD;
            end
            S_SORT_END: begin
               idx_ff   <= '0;
               state_ff <= swapped_ff ? S_SORT_LD0 : S_SORT_DONE;
            end
            S_SORT_DONE: begin
               idx_ff   <= '0;
               total_ff <= 32'd0;
               if (op_ff == OP_RECORD) begin
                  res_ff   <= new_entry;
                  state_ff <= S_REC_EMIT;
               end else begin
                  state_ff <= S_REP_RD;
               end
            end
            S_REC_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_is_total_ff    <= 1'b0;
                  rsp_entry_valid_ff <= 1'b1;
                  rsp_entry_ff       <= res_ff;
                  rsp_total_ff       <= 32'd0;
                  rsp_last_ff        <= 1'b1;
                  state_ff           <= S_IDLE;
               end
            end
            S_REP_RD: begin
               state_ff <= S_REP_CHK;
            end
            S_REP_CHK: begin
               if (idx_ff < fill_ff) begin
                  total_ff <= total_ff + rd_data_ff.count;
               end
               if (idx_ff < REP_N) begin
                  state_ff <= S_REP_EMIT;
               end else begin
                  idx_ff   <= idx_next;
                  state_ff <= (idx_next == FULL_N) ? S_TOTAL : S_REP_RD;
               end
            end
            S_REP_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_is_total_ff    <= 1'b0;
                  rsp_entry_valid_ff <= (idx_ff < fill_ff);
                  rsp_entry_ff       <= (idx_ff < fill_ff) ? rd_data_ff : '0;
                  rsp_total_ff       <= 32'd0;
                  rsp_last_ff        <= 1'b0;
                  idx_ff             <= idx_next;
                  state_ff           <= (idx_next == FULL_N) ? S_TOTAL : S_REP_RD;
               end
            end
            S_TOTAL: begin
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_is_total_ff    <= 1'b1;
                  rsp_entry_valid_ff <= 1'b0;
                  rsp_entry_ff       <= '0;
                  rsp_total_ff       <= total_ff;
                  rsp_last_ff        <= 1'b1;
                  state_ff           <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall           = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_is_total        = rsp_is_total_ff;
   assign rsp_entry_valid     = rsp_entry_valid_ff;
   assign rsp_entry_v6        = rsp_entry_ff.v6;
   assign rsp_entry_addr_high = rsp_entry_ff.hi;
   assign rsp_entry_addr_low  = rsp_entry_ff.lo;
   assign rsp_entry_owner     = rsp_entry_ff.owner;
   assign rsp_entry_count     = rsp_entry_ff.count;
   assign rsp_total_count     = rsp_total_ff;
   assign rsp_last            = rsp_last_ff;

endmodule
